FILE: design/fbfl_pkg.sv
package fbfl_pkg;

  localparam int DEF_PAGE_BYTES = 4096;
  localparam int MIN_BLOCK_BYTES = 16;
  localparam int MAX_BLOCKS = 256;

  localparam int SIZE_W = 13;
  localparam int IDX_W = 8;
  localparam int CNT_W = 9;
  localparam int OP_W = 2;
  localparam int ST_W = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE = 2'd1;
  localparam logic [OP_W-1:0] OP_REBUILD = 2'd2;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_FREE = 2'd2;

  localparam logic [SIZE_W-1:0] RESET_BLOCK_BYTES = SIZE_W'(MIN_BLOCK_BYTES);

  typedef struct packed {
    logic latch;        // capture the accepted request
    logic run;          // execute alloc, free or no-op and post the result
    logic build_init;   // start a rebuild walk
    logic build_step;   // carve one block and write its link
    logic build_done;   // commit the rebuilt pool and post the result
  } fbfl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic more;         // another block fits in the page and fewer than 256 are carved
    logic slot_free;    // output register can take a result this cycle
  } fbfl_stat_t;

endpackage

FILE: design/fixed_block_free_list_allocator.sv
// Fixed-size block pool kept as a LIFO free list of block indexes. A rebuild
// request samples block_bytes (raised to 16), carves the page into
// min(256, PAGE_BYTES / size) blocks and links them in order with the head at
// block 0; allocate pops the head, free pushes an index back and is rejected
// with status 2 when the index is out of range or the pool is already full.
// Allocate, free and the unused code are taken in S_IDLE and executed in
// S_EXEC, which uses the registered read of the link memory at the head. A
// rebuild walk subtracts the block size from the remaining page and writes
// one link per cycle through the single memory write port. A new request is
// taken while the previous result still waits in the output register;
// execution stalls only when that register is still full. No clearing pass
// runs after reset: links are written by the rebuild before they can be read.
module fixed_block_free_list_allocator import fbfl_pkg::*; #(
  parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   operation,
  input  logic [IDX_W-1:0]  freed_block,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  granted_block,
  output logic [ST_W-1:0]   status,
  output logic [CNT_W-1:0]  blocks_free,
  // block size register write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] block_bytes
);

  fbfl_cmd_t  cmd;
  fbfl_stat_t dp_stat;

  // register writes must arrive only while idle; unenforced, always taken
  assign cfg_ready = 1'b1;

  fbfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (dp_stat),
    .cmd      (cmd)
  );

  fbfl_dp #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (dp_stat),
    .operation     (operation),
    .freed_block   (freed_block),
    .cfg_valid     (cfg_valid),
    .block_bytes   (block_bytes),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .granted_block (granted_block),
    .status        (status),
    .blocks_free   (blocks_free)
  );

endmodule

FILE: design/fbfl_ctrl.sv
module fbfl_ctrl import fbfl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  fbfl_stat_t stat,
  output fbfl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_BUILD
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.op == OP_REBUILD) begin
          cmd.build_init = 1'b1;
          state_next = S_BUILD;
        end else if (stat.slot_free) begin
          cmd.run = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_BUILD: begin
        if (stat.more) begin
          cmd.build_step = 1'b1;
        end else if (stat.slot_free) begin
          cmd.build_done = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: design/fbfl_dp.sv
module fbfl_dp import fbfl_pkg::*; #(
  parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  fbfl_cmd_t         cmd,
  output fbfl_stat_t        stat,
  input  logic [OP_W-1:0]   operation,
  input  logic [IDX_W-1:0]  freed_block,
  input  logic              cfg_valid,
  input  logic [SIZE_W-1:0] block_bytes,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  granted_block,
  output logic [ST_W-1:0]   status,
  output logic [CNT_W-1:0]  blocks_free
);

  localparam int PW = $clog2(PAGE_BYTES + 1);
  localparam int RW = (PW > SIZE_W) ? PW : SIZE_W;

  logic [IDX_W-1:0]  link_mem [MAX_BLOCKS];
  logic [IDX_W-1:0]  rdata;

  logic [OP_W-1:0]   op_q;
  logic [IDX_W-1:0]  idx_q;
  logic [IDX_W-1:0]  head;
  logic [CNT_W-1:0]  free_total;
  logic [CNT_W-1:0]  block_total;
  logic [SIZE_W-1:0] size_cfg;
  logic [SIZE_W-1:0] size_q;
  logic [RW-1:0]     rem;
  logic [CNT_W-1:0]  cnt;

  logic [SIZE_W-1:0] size_clamped;
  logic              bad_free;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  wdata;

  assign size_clamped = (size_cfg < RESET_BLOCK_BYTES) ? RESET_BLOCK_BYTES : size_cfg;
  assign bad_free = ({1'b0, idx_q} >= block_total) || (free_total >= block_total);

  assign stat.op = op_q;
  assign stat.more = (rem >= RW'(size_q)) && (cnt != CNT_W'(MAX_BLOCKS));
  assign stat.slot_free = !out_valid || out_ready;

  // single write port shared by rebuild walk and free push
  assign we = cmd.build_step || (cmd.run && (op_q == OP_FREE) && !bad_free);
  assign waddr = cmd.build_step ? cnt[IDX_W-1:0] : idx_q;
  assign wdata = cmd.build_step ? (cnt[IDX_W-1:0] + IDX_W'(1)) : head;

  always_ff @(posedge clk) begin
    if (we) begin
      link_mem[waddr] <= wdata;
    end
    rdata <= link_mem[head];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q <= operation;
      idx_q <= freed_block;
    end
    if (cmd.build_init) begin
      rem <= RW'(PAGE_BYTES);
      cnt <= '0;
      size_q <= size_clamped;
    end else if (cmd.build_step) begin
      rem <= rem - RW'(size_q);
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      free_total <= '0;
      block_total <= '0;
      size_cfg <= RESET_BLOCK_BYTES;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        size_cfg <= block_bytes;
      end
      if (cmd.run || cmd.build_done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.build_done) begin
        head <= '0;
        free_total <= cnt;
        block_total <= cnt;
      end else if (cmd.run) begin
        case (op_q)
          OP_ALLOC: begin
            if (free_total != '0) begin
              head <= rdata;
              free_total <= free_total - CNT_W'(1);
            end
          end
          OP_FREE: begin
            if (!bad_free) begin
              head <= idx_q;
              free_total <= free_total + CNT_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.build_done) begin
      granted_block <= '0;
      status <= ST_OK;
      blocks_free <= cnt;
    end else if (cmd.run) begin
      granted_block <= '0;
      status <= ST_OK;
      blocks_free <= free_total;
      case (op_q)
        OP_ALLOC: begin
          if (free_total == '0) begin
            status <= ST_EMPTY;
          end else begin
            granted_block <= head;
            blocks_free <= free_total - CNT_W'(1);
          end
        end
        OP_FREE: begin
          if (bad_free) begin
            status <= ST_BAD_FREE;
          end else begin
            blocks_free <= free_total + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: verif/fbfl_pool_checker.sv
module fbfl_pool_checker import fbfl_pkg::*; #(
  parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [OP_W-1:0]   operation,
  input  logic [IDX_W-1:0]  freed_block,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [IDX_W-1:0]  granted_block,
  input  logic [ST_W-1:0]   status,
  input  logic [CNT_W-1:0]  blocks_free,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [SIZE_W-1:0] block_bytes,
  output int                mismatches,
  output int                pending,
  output int                results_seen,
  output int                empty_seen,
  output int                rejected_seen
);

  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [IDX_W-1:0] granted;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] free_after;
  } pool_answer_t;

  // shadow of the pool
  logic [IDX_W-1:0]  link_mem [MAX_BLOCKS];
  logic [CNT_W-1:0]  head_idx;
  logic [CNT_W-1:0]  free_cnt;
  logic [CNT_W-1:0]  pool_cnt;
  logic [SIZE_W-1:0] size_reg;

  pool_answer_t owed_answers [$];

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic pool_answer_t serve_request(input logic [OP_W-1:0] op,
                                                 input logic [IDX_W-1:0] idx);
    pool_answer_t ans;
    int carve;
    int count;
    ans.granted = '0;
    ans.status = ST_OK;
    case (op)
      OP_ALLOC: begin
        if (free_cnt == 0) begin
          ans.status = ST_EMPTY;
        end else begin
          ans.granted = head_idx[IDX_W-1:0];
          head_idx = CNT_W'(link_mem[ans.granted]);
          free_cnt = free_cnt - CNT_W'(1);
        end
      end
      OP_FREE: begin
        // out of range or already full: rejected, pool untouched
        if (CNT_W'(idx) >= pool_cnt || free_cnt >= pool_cnt) begin
          ans.status = ST_BAD_FREE;
        end else begin
          link_mem[idx] = head_idx[IDX_W-1:0];
          head_idx = CNT_W'(idx);
          free_cnt = free_cnt + CNT_W'(1);
        end
      end
      OP_REBUILD: begin
        carve = (int'(size_reg) < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : int'(size_reg);
        count = PAGE_BYTES / carve;
        if (count > MAX_BLOCKS) count = MAX_BLOCKS;
        for (int i = 0; i < count; i++) link_mem[i] = IDX_W'(i + 1);
        head_idx = '0;
        free_cnt = CNT_W'(count);
        pool_cnt = CNT_W'(count);
      end
      default: ;
    endcase
    ans.free_after = free_cnt;
    return ans;
  endfunction

  always @(posedge clk) begin
    pool_answer_t want;
    if (rst) begin
      head_idx = '0;
      free_cnt = '0;
      pool_cnt = '0;
      size_reg = RESET_BLOCK_BYTES;
      owed_answers.delete();
    end else begin
      // retire the response first so a same-edge request cannot mask a stray one
      if (out_valid && out_ready) begin
        if (owed_answers.size() == 0) begin
          report_mismatch($sformatf(
            "response with nothing outstanding: granted %0d status %0d free %0d",
            granted_block, status, blocks_free));
        end else begin
          want = owed_answers.pop_front();
          results_seen++;
          if (want.status == ST_EMPTY) empty_seen++;
          if (want.status == ST_BAD_FREE) rejected_seen++;
          if (granted_block !== want.granted)
            report_mismatch($sformatf("granted_block got %0d want %0d",
                                      granted_block, want.granted));
          if (status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", status, want.status));
          if (blocks_free !== want.free_after)
            report_mismatch($sformatf("blocks_free got %0d want %0d",
                                      blocks_free, want.free_after));
        end
      end
      if (cfg_valid && cfg_ready) size_reg = block_bytes;
      if (in_valid && in_ready) owed_answers.push_back(serve_request(operation, freed_block));
    end
    pending = owed_answers.size();
  end

endmodule

FILE: verif/fixed_block_free_list_allocator_tb.sv
module fixed_block_free_list_allocator_tb;
  import fbfl_pkg::*;

  // op code 3 has no name in the package, the block treats it as a no-op
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int PHASE_ITEMS  = 73;    // random requests per block size
  localparam int HOLD_CYCLES  = 150;   // long receiver hold-off to back up the block
  localparam int STALL_LIMIT  = 4000;  // cycles with no handshake before giving up
  localparam int DRAIN_CYCLES = 8;     // settle time after the last response

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [OP_W-1:0]   operation;
  logic [IDX_W-1:0]  freed_block;
  logic              out_valid;
  logic              out_ready;
  logic [IDX_W-1:0]  granted_block;
  logic [ST_W-1:0]   status;
  logic [CNT_W-1:0]  blocks_free;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [SIZE_W-1:0] block_bytes;

  int mismatches;
  int pending;
  int results_seen;
  int empty_seen;
  int rejected_seen;

  // idle odds for each side, in percent
  int send_idle_pct;
  int recv_idle_pct;

  // bumped by the stimulus to ask the receiver for one long hold-off
  int hold_token;
  int hold_seen;

  // blocks in the current pool, used to aim most frees at valid indexes
  int pool_blocks;

  int n_alloc;
  int n_free;
  int n_rebuild;
  int n_unused;
  int sizes_used;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fixed_block_free_list_allocator dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .freed_block   (freed_block),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .granted_block (granted_block),
    .status        (status),
    .blocks_free   (blocks_free),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .block_bytes   (block_bytes)
  );

  // watches all three channels, predicts each response and counts mismatches
  fbfl_pool_checker pool_chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .freed_block   (freed_block),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .granted_block (granted_block),
    .status        (status),
    .blocks_free   (blocks_free),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .block_bytes   (block_bytes),
    .mismatches    (mismatches),
    .pending       (pending),
    .results_seen  (results_seen),
    .empty_seen    (empty_seen),
    .rejected_seen (rejected_seen)
  );

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // offer one request and hold it until taken; returns on the falling edge
  // after the handshake with valid still high, so the caller must drive
  // in_valid again in this same step
  task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? int'($urandom_range(4, 1)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    freed_block <= idx;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    case (op)
      OP_ALLOC:   n_alloc++;
      OP_FREE:    n_free++;
      OP_REBUILD: n_rebuild++;
      default:    n_unused++;
    endcase
  endtask

  // the size register is only written with nothing in flight
  task automatic set_block_size(input logic [SIZE_W-1:0] bytes);
    int carve;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_valid   <= 1'b1;
    block_bytes <= bytes;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    // pool size the next rebuild will give, to aim the frees
    carve = (int'(bytes) < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : int'(bytes);
    pool_blocks = DEF_PAGE_BYTES / carve;
    if (pool_blocks > MAX_BLOCKS) pool_blocks = MAX_BLOCKS;
    sizes_used++;
  endtask

  // one block size: rebuild, then bursts that lean toward alloc or toward
  // free so small pools run dry and fill up again
  task automatic run_phase(input logic [SIZE_W-1:0] bytes, input int send_pct,
                           input int recv_pct, input bit squeeze);
    int alloc_pct;
    int pick;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    set_block_size(bytes);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    send_request(OP_REBUILD, IDX_W'($urandom));
    if (squeeze) hold_token++;
    alloc_pct = 50;
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      if (k % 20 == 0) alloc_pct = $urandom_range(1) ? 80 : 25;
      pick = $urandom_range(99);
      // the index is random on every op, it only matters on free
      idx = IDX_W'($urandom);
      if (pick < 2) begin
        op = OP_REBUILD;
      end else if (pick < 4) begin
        op = OP_UNUSED;
      end else if ($urandom_range(99) < alloc_pct) begin
        op = OP_ALLOC;
      end else begin
        op = OP_FREE;
        // mostly in range, the rest anywhere in the field
        if ($urandom_range(99) < 85) idx = IDX_W'($urandom_range(pool_blocks - 1));
      end
      send_request(op, idx);
    end
  endtask

  // no-progress watchdog
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    operation   = OP_ALLOC;
    freed_block = '0;
    cfg_valid   = 1'b0;
    block_bytes = RESET_BLOCK_BYTES;
    send_idle_pct = 15;
    recv_idle_pct = 72;
    pool_blocks   = MAX_BLOCKS;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed, reset block size of 16 gives a full 256-block page
    send_request(OP_ALLOC, 8'hFF);      // no pool yet: empty
    send_request(OP_FREE, 8'h00);       // no pool yet: rejected
    send_request(OP_FREE, 8'hFF);       // no pool yet: rejected
    send_request(OP_UNUSED, 8'hAA);     // unused code is a no-op
    send_request(OP_REBUILD, 8'h00);
    send_request(OP_ALLOC, 8'h00);      // block 0
    send_request(OP_ALLOC, 8'h00);      // block 1
    send_request(OP_FREE, 8'hFF);       // top index back on the list
    send_request(OP_FREE, 8'hFF);       // double free while not full is taken
    send_request(OP_FREE, 8'h00);       // pool now full: rejected
    send_request(OP_ALLOC, 8'h00);      // 255
    send_request(OP_ALLOC, 8'h00);      // 255 again from the double free
    send_request(OP_UNUSED, 8'h55);

    // directed, one block per page
    set_block_size(13'd4096);
    send_request(OP_REBUILD, 8'hFF);
    send_request(OP_ALLOC, 8'h00);      // block 0
    send_request(OP_ALLOC, 8'h00);      // empty
    send_request(OP_FREE, 8'h01);       // out of range
    send_request(OP_FREE, 8'h00);
    send_request(OP_FREE, 8'h00);       // full
    send_request(OP_ALLOC, 8'h00);

    // sender mostly busy, receiver mostly stalling
    run_phase(13'd0, 15, 72, 1'b0);
    run_phase(13'd512, 15, 72, 1'b0);
    run_phase(13'd17, 15, 72, 1'b0);
    run_phase(13'd256, 15, 72, 1'b0);
    // the other way round
    run_phase(13'd4095, 72, 15, 1'b0);
    run_phase(13'd1024, 72, 15, 1'b0);
    run_phase(13'd128, 72, 15, 1'b0);
    run_phase(13'd2048, 72, 15, 1'b0);
    // no idling; the first one backs the block up behind a long hold-off
    run_phase(13'd64, 0, 0, 1'b1);
    run_phase(13'd4096, 0, 0, 1'b0);
    run_phase(SIZE_W'($urandom_range(4096, 16)), 0, 0, 1'b0);
    run_phase(SIZE_W'($urandom_range(4096, 0)), 0, 0, 1'b0);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d requests (%0d alloc, %0d free, %0d rebuild, %0d unused code)",
             n_alloc + n_free + n_rebuild + n_unused, n_alloc, n_free, n_rebuild, n_unused);
    $display("over %0d block sizes, %0d responses checked, %0d on an empty pool,",
             sizes_used + 1, results_seen, empty_seen);
    $display("%0d rejected frees, %0d mismatches", rejected_seen, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
